FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define BCAM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define BCAM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bcam_pkg.sv
// ---------------------------------------------------------------------------
// bcam_pkg
// Opcodes, print kinds and ALU request/response types for the byte-code ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package bcam_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int STEPS   = BYTE_W;
  localparam int CNT_W   = $clog2(STEPS);

  localparam logic [7:0] OP_ADD        = 8'h00;
  localparam logic [7:0] OP_SUB        = 8'h01;
  localparam logic [7:0] OP_MUL        = 8'h02;
  localparam logic [7:0] OP_DIV        = 8'h03;
  localparam logic [7:0] OP_AND        = 8'h04;
  localparam logic [7:0] OP_OR         = 8'h05;
  localparam logic [7:0] OP_XOR        = 8'h06;
  localparam logic [7:0] OP_PRINT_INT  = 8'h10;
  localparam logic [7:0] OP_PRINT_CHAR = 8'h11;

  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef logic [2:0] alu_op_t;

  localparam alu_op_t ALU_ADD = 3'd0;
  localparam alu_op_t ALU_SUB = 3'd1;
  localparam alu_op_t ALU_MUL = 3'd2;
  localparam alu_op_t ALU_DIV = 3'd3;
  localparam alu_op_t ALU_AND = 3'd4;
  localparam alu_op_t ALU_OR  = 3'd5;
  localparam alu_op_t ALU_XOR = 3'd6;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

FILE: src/bcam_alu.sv
// ---------------------------------------------------------------------------
// bcam_alu
// Iterative 8-bit ALU around one shared 9-bit adder. Add, subtract and logic
// finish in one step; multiply (shift-add) and divide (restoring) take eight steps.
// ---------------------------------------------------------------------------
`default_nettype none

module bcam_alu (
  input  wire logic          clk,
  input  wire logic          rst,
  input  bcam_pkg::alu_req_t req,
  output bcam_pkg::alu_rsp_t rsp
);
  import bcam_pkg::*;

  logic              running;
  logic [CNT_W-1:0]  step_cnt;
  alu_op_t           op;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] hi;
  logic [BYTE_W-1:0] lo;

  logic [BYTE_W:0]   add_x;
  logic [BYTE_W:0]   add_y;
  logic              add_cin;
  logic [BYTE_W+1:0] add_sum;

  logic [BYTE_W-1:0] hi_next;
  logic [BYTE_W-1:0] lo_next;
  logic              iterative;
  logic              last_step;
  logic [WORD_W-1:0] result_next;

  // shared adder
  always_comb begin
    add_x   = {1'b0, a};
    add_y   = {1'b0, b};
    add_cin = 1'b0;
    case (op)
      ALU_SUB: begin
        add_y   = ~{1'b0, b};
        add_cin = 1'b1;
      end
      ALU_DIV: begin
        add_x   = {hi, lo[BYTE_W-1]};
        add_y   = ~{1'b0, b};
        add_cin = 1'b1;
      end
      ALU_MUL: begin
        add_x = {1'b0, hi};
        add_y = lo[0] ? {1'b0, a} : '0;
      end
      default: ;
    endcase
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(BYTE_W+1){1'b0}}, add_cin};
  end

  // one multiply/divide step
  always_comb begin
    if (op == ALU_MUL) begin
      hi_next = add_sum[BYTE_W:1];
      lo_next = {add_sum[0], lo[BYTE_W-1:1]};
    end else begin
      hi_next = add_sum[BYTE_W+1] ? add_sum[BYTE_W-1:0] : add_x[BYTE_W-1:0];
      lo_next = {lo[BYTE_W-2:0], add_sum[BYTE_W+1]};
    end
  end

  assign iterative = (op == ALU_MUL) || (op == ALU_DIV);
  assign last_step = !iterative || (step_cnt == CNT_W'(STEPS - 1));

  always_comb begin
    case (op)
      ALU_ADD: result_next = {{(WORD_W-BYTE_W-1){1'b0}}, add_sum[BYTE_W:0]};
      ALU_SUB: result_next = {{(WORD_W-BYTE_W-1){add_sum[BYTE_W]}}, add_sum[BYTE_W:0]};
      ALU_MUL: result_next = {{(WORD_W-2*BYTE_W){1'b0}}, hi_next, lo_next};
      ALU_DIV: result_next = (b == '0) ? '0 : {{(WORD_W-BYTE_W){1'b0}}, lo_next};
      ALU_AND: result_next = {{(WORD_W-BYTE_W){1'b0}}, a & b};
      ALU_OR:  result_next = {{(WORD_W-BYTE_W){1'b0}}, a | b};
      default: result_next = {{(WORD_W-BYTE_W){1'b0}}, a ^ b};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      step_cnt <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        running  <= 1'b1;
        step_cnt <= '0;
      end else if (running) begin
        step_cnt <= step_cnt + CNT_W'(1);
        if (last_step) begin
          running    <= 1'b0;
          rsp.done   <= 1'b1;
          rsp.result <= result_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op <= req.op;
      a  <= req.a;
      b  <= req.b;
      hi <= '0;
      lo <= (req.op == ALU_MUL) ? req.b : req.a;
    end else if (running) begin
      hi <= hi_next;
      lo <= lo_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/bcam_regfile.sv
// ---------------------------------------------------------------------------
// bcam_regfile
// Register file with one write and one read port, cleared at reset.
// ---------------------------------------------------------------------------
`default_nettype none

module bcam_regfile #(
  parameter int NUM_REGS = 12,
  parameter int IDX_W    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        we,
  input  wire logic [IDX_W-1:0]            waddr,
  input  wire logic [bcam_pkg::WORD_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]            raddr,
  output logic      [bcam_pkg::WORD_W-1:0] rdata
);
  import bcam_pkg::*;

  logic [WORD_W-1:0] regs [NUM_REGS];
  logic              rd_ok;
  logic              wr_ok;

  assign rd_ok = {1'b0, raddr} < (IDX_W+1)'(NUM_REGS);
  assign wr_ok = {1'b0, waddr} < (IDX_W+1)'(NUM_REGS);
  assign rdata = rd_ok ? regs[raddr] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (we && wr_ok) begin
      regs[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: src/byte_code_alu_machine.sv
// Opcode, destination and first immediate bytes are each taken in one transfer;
// a print result is registered in the cycle after its register byte transfer.
// The second immediate starts the ALU: one step for add/sub/logic, the 8 steps
// of the shared adder for multiply/divide; no byte is taken while it runs.
// Reset (rst, synchronous) clears the decode state, m_tvalid and the register file.
// ---------------------------------------------------------------------------
// byte_code_alu_machine
// Byte-code decoder with a register file, an iterative ALU and print output.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_code_alu_machine #(
  parameter int NUM_REGS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] code_byte
  input  wire logic        s_tlast,  // last_of_program
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,  // [7:0] reg_index, [39:8] reg_value
  output logic      [1:0]  m_tuser   // [1:0] print_kind
);
  import bcam_pkg::*;

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [2:0] ST_OPCODE = 3'd0;
  localparam logic [2:0] ST_DEST   = 3'd1;
  localparam logic [2:0] ST_FIRST  = 3'd2;
  localparam logic [2:0] ST_SECOND = 3'd3;
  localparam logic [2:0] ST_EXEC   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [7:0]        held_opcode;
  logic [7:0]        held_dest;
  logic [7:0]        held_first;

  logic              accept;
  logic              is_print;
  logic              known_op;
  logic              emit;
  logic              idx_ok;
  logic              dest_ok;
  logic [WORD_W-1:0] rd_data;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign s_tready = (state != ST_EXEC) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_print = (held_opcode == OP_PRINT_INT) || (held_opcode == OP_PRINT_CHAR);
  assign known_op = (s_tdata <= OP_XOR) || (s_tdata == OP_PRINT_INT) ||
                    (s_tdata == OP_PRINT_CHAR);
  assign emit     = accept && (state == ST_DEST) && is_print;
  assign idx_ok   = {1'b0, s_tdata} < 9'(NUM_REGS);
  assign dest_ok  = {1'b0, held_dest} < 9'(NUM_REGS);

  always_comb begin
    alu_req.start = accept && (state == ST_SECOND);
    alu_req.op    = held_opcode[2:0];
    alu_req.a     = held_first;
    alu_req.b     = s_tdata;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_OPCODE: if (accept && known_op) state_next = ST_DEST;
      ST_DEST:   if (accept) state_next = is_print ? ST_OPCODE : ST_FIRST;
      ST_FIRST:  if (accept) state_next = ST_SECOND;
      ST_SECOND: if (accept) state_next = ST_EXEC;
      ST_EXEC:   if (alu_rsp.done) state_next = ST_OPCODE;
      default:   state_next = ST_OPCODE;
    endcase
    if (accept && s_tlast && (state != ST_SECOND)) begin
      state_next = ST_OPCODE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_OPCODE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (state == ST_OPCODE) && known_op) begin
      held_opcode <= s_tdata;
    end
    if (accept && (state == ST_DEST) && !is_print) begin
      held_dest <= s_tdata;
    end
    if (accept && (state == ST_FIRST)) begin
      held_first <= s_tdata;
    end
    if (emit) begin
      m_tdata[7:0]  <= s_tdata;
      m_tdata[39:8] <= idx_ok ? rd_data : '0;
      m_tuser       <= !idx_ok ? KIND_BAD :
                       (held_opcode == OP_PRINT_INT) ? KIND_INT : KIND_CHAR;
    end
  end

  bcam_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  bcam_regfile #(
    .NUM_REGS (NUM_REGS),
    .IDX_W    (IDX_W)
  ) u_regfile (
    .clk   (clk),
    .rst   (rst),
    .we    (alu_rsp.done && dest_ok),
    .waddr (held_dest[IDX_W-1:0]),
    .wdata (alu_rsp.result),
    .raddr (s_tdata[IDX_W-1:0]),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

FILE: src/bcam_checker.sv
// ---------------------------------------------------------------------------
// bcam_checker
// Port-level assertions for byte_code_alu_machine, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bcam_checker #(
  parameter int NUM_REGS = 12
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import bcam_pkg::*;

  `BCAM_ASSERT_NR(a_reset_clears_out, clk, rst |=> !m_tvalid, "output valid after reset")

  `BCAM_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output transfer changed")

  `BCAM_ASSERT(a_bad_index_kind, clk, rst, m_tvalid && ({1'b0, m_tdata[7:0]} >= 9'(NUM_REGS)) |-> m_tuser == KIND_BAD, "out-of-range print not flagged")

  `BCAM_ASSERT(a_bad_kind_zero, clk, rst, m_tvalid && (m_tuser == KIND_BAD) |-> m_tdata[39:8] == 32'd0, "bad-index print carries a value")

endmodule

bind byte_code_alu_machine bcam_checker #(
  .NUM_REGS (NUM_REGS)
) u_bcam_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
